// ===== rtl/core/cccp_pkg.sv =====
// Shared types and character codes for the chat colour code parser.
// Used by cccp_front, cccp_queue, cccp_back and the top level.
package cccp_pkg;

	// Character codes recognized by the parser
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_CTRL  = 8'h03;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LC_C  = 8'h63;
	localparam logic [7:0] CH_UC_C  = 8'h43;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_U  = 8'h75;
	localparam logic [7:0] CH_LC_I  = 8'h69;

	// Highest colour index that a code may select
	localparam logic [6:0] MAX_COLOUR = 7'd15;

	// Style bit positions
	localparam int STY_BOLD   = 0;
	localparam int STY_UNDER  = 1;
	localparam int STY_ITALIC = 2;

	// Depth of the request queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LEAD  = 3'd1,
		PH_FG1   = 3'd2,
		PH_FG2   = 3'd3,
		PH_COMMA = 3'd4,
		PH_BG1   = 3'd5
	} phase_t;

	typedef struct packed {
		logic       fg_def;
		logic [3:0] fg_idx;
		logic       bg_def;
		logic [3:0] bg_idx;
		logic [2:0] style;
	} attr_t;

	typedef struct packed {
		phase_t     phase;
		logic       lead_ctrl;
		logic [6:0] fg_digits;
		logic [6:0] bg_digits;
		attr_t      attr;
	} parse_st_t;

	// One display request: a byte, or a '~' followed by the byte when pair is set
	typedef struct packed {
		logic       pair;
		logic [7:0] chr;
		attr_t      attr;
	} rec_t;

endpackage

// ===== rtl/core/cccp_front.sv =====
// Front end of the chat colour code parser: accepts text bytes, runs the
// code parser and pushes display requests. Depends on cccp_pkg.
module cccp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    text_byte,
	input  logic          end_of_text,
	input  logic          q_full,
	output logic          q_push,
	output cccp_pkg::rec_t q_rec
);
	import cccp_pkg::*;

	parse_st_t  st_q;
	parse_st_t  nx_st;
	logic       accept;
	logic       is_dig;
	logic       is_lead;
	logic [3:0] dig;
	logic       ns_feed;
	logic       o_feed;
	logic       tilde_pre;
	logic       tilde_lit;
	logic       tilde_post;
	logic       push_b;

	function automatic parse_st_t finish_colour(parse_st_t s, logic has_bg);
		parse_st_t r;
		r = s;
		if (s.fg_digits <= MAX_COLOUR) begin
			r.attr.fg_def = 1'b0;
			r.attr.fg_idx = s.fg_digits[3:0];
		end
		r.attr.bg_def = 1'b1;
		if (has_bg && (s.bg_digits <= MAX_COLOUR)) begin
			r.attr.bg_def = 1'b0;
			r.attr.bg_idx = s.bg_digits[3:0];
		end
		r.phase = PH_IDLE;
		return r;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_dig   = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign is_lead  = (text_byte == CH_TILDE) || (text_byte == CH_CTRL);
	assign dig      = text_byte[3:0];

	// Next state
	always_comb begin
		nx_st   = st_q;
		ns_feed = 1'b0;
		case (st_q.phase)
			PH_LEAD: begin
				nx_st.phase = PH_IDLE;
				if (is_dig) begin
					nx_st.fg_digits = {3'b000, dig};
					nx_st.phase     = PH_FG1;
				end else if (text_byte == CH_LC_C) begin
					nx_st.attr.fg_def = 1'b1;
					nx_st.attr.bg_def = 1'b1;
				end else if (text_byte == CH_UC_C) begin
					nx_st.attr.fg_def = 1'b1;
					nx_st.attr.bg_def = 1'b1;
					nx_st.attr.style  = 3'b000;
				end else if (text_byte == CH_LC_B) begin
					nx_st.attr.style[STY_BOLD] = !st_q.attr.style[STY_BOLD];
				end else if (text_byte == CH_LC_U) begin
					nx_st.attr.style[STY_UNDER] = !st_q.attr.style[STY_UNDER];
				end else if (text_byte == CH_LC_I) begin
					nx_st.attr.style[STY_ITALIC] = !st_q.attr.style[STY_ITALIC];
				end else if (text_byte != CH_TILDE) begin
					if (st_q.lead_ctrl) begin
						nx_st.attr.fg_def = 1'b1;
						nx_st.attr.bg_def = 1'b1;
					end
					ns_feed = 1'b1;
				end
			end
			PH_FG1: begin
				if (is_dig) begin
					nx_st.fg_digits = 7'(st_q.fg_digits * 7'd10 + {3'b000, dig});
					nx_st.phase     = PH_FG2;
				end else if (text_byte == CH_COMMA) begin
					nx_st.phase = PH_COMMA;
				end else begin
					nx_st   = finish_colour(st_q, 1'b0);
					ns_feed = 1'b1;
				end
			end
			PH_FG2: begin
				if (text_byte == CH_COMMA) begin
					nx_st.phase = PH_COMMA;
				end else begin
					nx_st   = finish_colour(st_q, 1'b0);
					ns_feed = 1'b1;
				end
			end
			PH_COMMA: begin
				if (is_dig) begin
					nx_st.bg_digits = {3'b000, dig};
					nx_st.phase     = PH_BG1;
				end else begin
					nx_st   = finish_colour(st_q, 1'b0);
					ns_feed = 1'b1;
				end
			end
			PH_BG1: begin
				if (is_dig) begin
					nx_st.bg_digits = 7'(st_q.bg_digits * 7'd10 + {3'b000, dig});
					nx_st           = finish_colour(nx_st, 1'b1);
				end else begin
					nx_st   = finish_colour(st_q, 1'b1);
					ns_feed = 1'b1;
				end
			end
			default: begin
				ns_feed = 1'b1;
			end
		endcase

		// Plain text handling: a lead opens a new code
		if (ns_feed) begin
			nx_st.phase = PH_IDLE;
			if (is_lead) begin
				nx_st.phase     = PH_LEAD;
				nx_st.lead_ctrl = (text_byte == CH_CTRL);
			end
		end

		// End of text: complete any pending code
		if (end_of_text) begin
			case (nx_st.phase)
				PH_LEAD: begin
					if (nx_st.lead_ctrl) begin
						nx_st.attr.fg_def = 1'b1;
						nx_st.attr.bg_def = 1'b1;
					end
				end
				PH_FG1, PH_FG2, PH_COMMA: begin
					nx_st = finish_colour(nx_st, 1'b0);
				end
				PH_BG1: begin
					nx_st = finish_colour(nx_st, 1'b1);
				end
				default: begin
				end
			endcase
			nx_st.phase = PH_IDLE;
		end
	end

	// Outputs: which bytes this input shows
	always_comb begin
		o_feed    = 1'b0;
		tilde_pre = 1'b0;
		tilde_lit = 1'b0;
		case (st_q.phase)
			PH_LEAD: begin
				if (text_byte == CH_TILDE) begin
					tilde_lit = 1'b1;
				end else if (!(is_dig || (text_byte == CH_LC_C) || (text_byte == CH_UC_C)
						|| (text_byte == CH_LC_B) || (text_byte == CH_LC_U)
						|| (text_byte == CH_LC_I))) begin
					tilde_pre = !st_q.lead_ctrl;
					o_feed    = 1'b1;
				end
			end
			PH_FG1:   o_feed = !(is_dig || (text_byte == CH_COMMA));
			PH_FG2:   o_feed = (text_byte != CH_COMMA);
			PH_COMMA: o_feed = !is_dig;
			PH_BG1:   o_feed = !is_dig;
			default:  o_feed = 1'b1;
		endcase
		push_b     = o_feed && !is_lead;
		// a '~' that opens a code cut short by end of text still prints
		tilde_post = end_of_text && o_feed && (text_byte == CH_TILDE);

		q_push     = accept && (push_b || tilde_pre || tilde_lit || tilde_post);
		q_rec.pair = tilde_pre && push_b;
		q_rec.chr  = push_b ? text_byte : CH_TILDE;
		// a leading '~' shows before end of text can reset the colours of a new 0x03 code
		q_rec.attr = tilde_pre ? st_q.attr : nx_st.attr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase        <= PH_IDLE;
			st_q.lead_ctrl    <= 1'b0;
			st_q.fg_digits    <= '0;
			st_q.bg_digits    <= '0;
			st_q.attr.fg_def  <= 1'b1;
			st_q.attr.fg_idx  <= '0;
			st_q.attr.bg_def  <= 1'b1;
			st_q.attr.bg_idx  <= '0;
			st_q.attr.style   <= '0;
		end else if (accept) begin
			st_q <= nx_st;
		end
	end

endmodule

// ===== rtl/core/cccp_queue.sv =====
// Small request queue between the parser front and the output back end.
// Depends on cccp_pkg for the request type and depth.
module cccp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cccp_pkg::rec_t push_rec,
	output logic           full,
	input  logic           pop,
	output cccp_pkg::rec_t head_rec,
	output logic           empty
);
	import cccp_pkg::*;

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign head_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/cccp_back.sv =====
// Back end of the chat colour code parser: takes requests from the queue
// and drives the registered result channel. Depends on cccp_pkg.
module cccp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  cccp_pkg::rec_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     shown_byte,
	output logic           fg_is_default,
	output logic [3:0]     fg_index,
	output logic           bg_is_default,
	output logic [3:0]     bg_index,
	output logic           bold_on,
	output logic           underline_on,
	output logic           italic_on,
	output logic           last_of_run
);
	import cccp_pkg::*;

	logic       out_valid_q;
	logic       second_q;
	rec_t       held_q;
	logic [7:0] chr_q;
	attr_t      attr_q;
	logic       last_q;
	logic       load;

	assign load  = !out_valid_q || out_ready;
	assign q_pop = load && !second_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				out_valid_q <= 1'b1;
				second_q    <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				second_q    <= q_head.pair;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: a paired request shows '~' first, then holds the byte for a second beat
	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				chr_q  <= held_q.chr;
				attr_q <= held_q.attr;
				last_q <= 1'b1;
			end else if (!q_empty) begin
				held_q <= q_head;
				chr_q  <= q_head.pair ? CH_TILDE : q_head.chr;
				attr_q <= q_head.attr;
				last_q <= !q_head.pair;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign shown_byte    = chr_q;
	assign fg_is_default = attr_q.fg_def;
	assign fg_index      = attr_q.fg_idx;
	assign bg_is_default = attr_q.bg_def;
	assign bg_index      = attr_q.bg_idx;
	assign bold_on       = attr_q.style[STY_BOLD];
	assign underline_on  = attr_q.style[STY_UNDER];
	assign italic_on     = attr_q.style[STY_ITALIC];
	assign last_of_run   = last_q;

endmodule

// ===== rtl/core/chat_colour_code_parser.sv =====
// Chat colour code parser: strips '~' and 0x03 formatting codes from a byte
// stream and shows each visible byte with its colour and style attributes.
// The parser front takes one text byte per cycle while the queue is not full and
// pushes at most one display request per byte into a four-entry queue; the back
// end drains it into a registered output. A byte produces zero, one or two
// results; in the two-result case (a lone '~' before a plain byte) the back end
// stops popping while it shows the second result, which the queue absorbs.
// Depends on cccp_pkg, cccp_front, cccp_queue, cccp_back.
module chat_colour_code_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] shown_byte,
	output logic       fg_is_default,
	output logic [3:0] fg_index,
	output logic       bg_is_default,
	output logic [3:0] bg_index,
	output logic       bold_on,
	output logic       underline_on,
	output logic       italic_on,
	output logic       last_of_run
);
	import cccp_pkg::*;

	logic q_full;
	logic q_push;
	rec_t q_rec;
	logic q_pop;
	rec_t q_head;
	logic q_empty;

	cccp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_rec       (q_rec)
	);

	cccp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_rec),
		.full     (q_full),
		.pop      (q_pop),
		.head_rec (q_head),
		.empty    (q_empty)
	);

	cccp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.shown_byte    (shown_byte),
		.fg_is_default (fg_is_default),
		.fg_index      (fg_index),
		.bg_is_default (bg_is_default),
		.bg_index      (bg_index),
		.bold_on       (bold_on),
		.underline_on  (underline_on),
		.italic_on     (italic_on),
		.last_of_run   (last_of_run)
	);

endmodule

// ===== dv/chat_colour_code_parser_tb.sv =====
// Self-checking testbench for chat_colour_code_parser: streams text bytes through
// valid/ready with random gaps and stalls, and checks every shown byte and attribute.
// Depends on cccp_pkg and the chat_colour_code_parser RTL.
`timescale 1ns / 1ps

module chat_colour_code_parser_tb;
	import cccp_pkg::*;

	localparam int RANDOM_BYTES = 1250;
	localparam int STUCK_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 20;

	typedef struct packed {
		logic [7:0] chr;
		logic       eot;
	} text_item_t;

	typedef struct packed {
		logic [7:0] chr;
		logic       fg_def;
		logic [3:0] fg_idx;
		logic       bg_def;
		logic [3:0] bg_idx;
		logic [2:0] style;
		logic       last;
	} glyph_t;

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_ready;
	logic [7:0] text_byte     = 8'h00;
	logic       end_of_text   = 1'b0;
	logic       out_valid;
	logic       out_ready     = 1'b0;
	logic [7:0] shown_byte;
	logic       fg_is_default;
	logic [3:0] fg_index;
	logic       bg_is_default;
	logic [3:0] bg_index;
	logic       bold_on;
	logic       underline_on;
	logic       italic_on;
	logic       last_of_run;

	chat_colour_code_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_byte     (text_byte),
		.end_of_text   (end_of_text),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.shown_byte    (shown_byte),
		.fg_is_default (fg_is_default),
		.fg_index      (fg_index),
		.bg_is_default (bg_is_default),
		.bg_index      (bg_index),
		.bold_on       (bold_on),
		.underline_on  (underline_on),
		.italic_on     (italic_on),
		.last_of_run   (last_of_run)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	text_item_t text_q[$];
	glyph_t     glyph_q[$];
	glyph_t     step_q[$];

	// Parser state as predicted
	phase_t     p_phase     = PH_IDLE;
	logic       p_lead_ctrl = 1'b0;
	logic [6:0] p_fg_acc    = '0;
	logic [6:0] p_bg_acc    = '0;
	logic       p_fg_def    = 1'b1;
	logic [3:0] p_fg_idx    = '0;
	logic       p_bg_def    = 1'b1;
	logic [3:0] p_bg_idx    = '0;
	logic [2:0] p_style     = '0;

	bit in_taken  = 1'b0;
	bit out_taken = 1'b0;
	bit in_rush   = 1'b0;
	bit out_rush  = 1'b0;
	int in_wait   = 0;
	int out_wait  = 0;
	int stuck     = 0;
	int n_in      = 0;
	int n_eot     = 0;
	int n_out     = 0;
	int n_bad     = 0;

	task automatic show_char(input logic [7:0] c);
		glyph_t g;
		g.chr    = c;
		g.fg_def = p_fg_def;
		g.fg_idx = p_fg_idx;
		g.bg_def = p_bg_def;
		g.bg_idx = p_bg_idx;
		g.style  = p_style;
		g.last   = 1'b0;
		step_q.push_back(g);
	endtask

	task automatic colours_to_default();
		p_fg_def = 1'b1;
		p_bg_def = 1'b1;
	endtask

	// Apply the collected colour code; a foreground index past the maximum leaves it alone, the background goes to default
	task automatic close_colour(input logic with_bg);
		if (p_fg_acc <= MAX_COLOUR) begin
			p_fg_def = 1'b0;
			p_fg_idx = p_fg_acc[3:0];
		end
		p_bg_def = 1'b1;
		if (with_bg && p_bg_acc <= MAX_COLOUR) begin
			p_bg_def = 1'b0;
			p_bg_idx = p_bg_acc[3:0];
		end
		p_phase = PH_IDLE;
	endtask

	task automatic take_fresh(input logic [7:0] c);
		p_phase = PH_IDLE;
		if (c == CH_TILDE || c == CH_CTRL) begin
			p_phase     = PH_LEAD;
			p_lead_ctrl = (c == CH_CTRL);
		end else begin
			show_char(c);
		end
	endtask

	task automatic parse_text_byte(input logic [7:0] c, input logic eot);
		logic       is_dig;
		logic [6:0] dval;
		glyph_t     g;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		dval   = 7'(c - CH_ZERO);
		step_q.delete();
		case (p_phase)
			PH_LEAD: begin
				p_phase = PH_IDLE;
				if (is_dig) begin
					p_fg_acc = dval;
					p_phase  = PH_FG1;
				end else if (c == CH_LC_C) begin
					colours_to_default();
				end else if (c == CH_UC_C) begin
					colours_to_default();
					p_style = '0;
				end else if (c == CH_LC_B) begin
					p_style[STY_BOLD] = ~p_style[STY_BOLD];
				end else if (c == CH_LC_U) begin
					p_style[STY_UNDER] = ~p_style[STY_UNDER];
				end else if (c == CH_LC_I) begin
					p_style[STY_ITALIC] = ~p_style[STY_ITALIC];
				end else if (c == CH_TILDE) begin
					show_char(c);
				end else begin
					if (p_lead_ctrl)
						colours_to_default();
					else
						show_char(CH_TILDE);
					take_fresh(c);
				end
			end
			PH_FG1: begin
				if (is_dig) begin
					p_fg_acc = 7'(p_fg_acc * 10 + dval);
					p_phase  = PH_FG2;
				end else if (c == CH_COMMA) begin
					p_phase = PH_COMMA;
				end else begin
					close_colour(1'b0);
					take_fresh(c);
				end
			end
			PH_FG2: begin
				if (c == CH_COMMA) begin
					p_phase = PH_COMMA;
				end else begin
					close_colour(1'b0);
					take_fresh(c);
				end
			end
			PH_COMMA: begin
				if (is_dig) begin
					p_bg_acc = dval;
					p_phase  = PH_BG1;
				end else begin
					close_colour(1'b0);
					take_fresh(c);
				end
			end
			PH_BG1: begin
				if (is_dig) begin
					p_bg_acc = 7'(p_bg_acc * 10 + dval);
					close_colour(1'b1);
				end else begin
					close_colour(1'b1);
					take_fresh(c);
				end
			end
			default: take_fresh(c);
		endcase

		// End of text completes whatever code is still open
		if (eot) begin
			case (p_phase)
				PH_LEAD: begin
					if (p_lead_ctrl)
						colours_to_default();
					else
						show_char(CH_TILDE);
				end
				PH_FG1, PH_FG2, PH_COMMA: close_colour(1'b0);
				PH_BG1: close_colour(1'b1);
				default: ;
			endcase
			p_phase = PH_IDLE;
		end

		if (step_q.size() > 0) begin
			g = step_q.pop_back();
			g.last = 1'b1;
			step_q.push_back(g);
		end
		foreach (step_q[k])
			glyph_q.push_back(step_q[k]);
	endtask

	// Stall length for one request, with occasional stretches of back-to-back traffic
	function automatic int pick_wait(inout bit rush);
		if ($urandom_range(0, 39) == 0)
			rush = ~rush;
		return rush ? 0 : $urandom_range(0, 11);
	endfunction

	always @(negedge clk) begin
		text_item_t nxt;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (in_wait > 0) begin
					in_wait--;
					in_valid <= 1'b0;
				end else if (text_q.size() > 0) begin
					nxt = text_q.pop_front();
					text_byte   <= nxt.chr;
					end_of_text <= nxt.eot;
					in_valid    <= 1'b1;
					in_wait = pick_wait(in_rush);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				out_taken = 1'b0;
				out_wait  = pick_wait(out_rush);
			end
			if (out_wait > 0) begin
				out_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		glyph_t got;
		glyph_t want;
		bit     moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && in_ready) begin
				parse_text_byte(text_byte, end_of_text);
				in_taken = 1'b1;
				moved    = 1'b1;
				n_in++;
				if (end_of_text)
					n_eot++;
			end
			if (out_valid && out_ready) begin
				out_taken = 1'b1;
				moved     = 1'b1;
				got.chr    = shown_byte;
				got.fg_def = fg_is_default;
				got.fg_idx = fg_index;
				got.bg_def = bg_is_default;
				got.bg_idx = bg_index;
				got.style  = {italic_on, underline_on, bold_on};
				got.last   = last_of_run;
				if (glyph_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: unexpected result byte %02h", $realtime, got.chr);
				end else begin
					want = glyph_q.pop_front();
					n_out++;
					if (got !== want) begin
						n_bad++;
						if (n_bad <= 10) begin
							$write("%0t: mismatch byte %02h/%02h fg %b:%0d/%b:%0d ",
								$realtime, want.chr, got.chr,
								want.fg_def, want.fg_idx, got.fg_def, got.fg_idx);
							$display("bg %b:%0d/%b:%0d style %03b/%03b last %b/%b (exp/got)",
								want.bg_def, want.bg_idx, got.bg_def, got.bg_idx,
								want.style, got.style, want.last, got.last);
						end
					end
				end
			end

			if (moved || (text_q.size() == 0 && !in_valid && glyph_q.size() == 0))
				stuck = 0;
			else
				stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("Watchdog: no request moved for %0d cycles", stuck);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic add_byte(input logic [7:0] c, input logic eot);
		text_item_t t;
		t.chr = c;
		t.eot = eot;
		text_q.push_back(t);
	endtask

	task automatic add_text(input string s);
		for (int k = 0; k < s.len(); k++)
			add_byte(8'(s[k]), 1'b0);
	endtask

	function automatic logic [7:0] any_lead();
		return $urandom_range(0, 1) ? CH_TILDE : CH_CTRL;
	endfunction

	function automatic logic [7:0] any_digit();
		return 8'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	function automatic logic rare_eot();
		return $urandom_range(0, 19) == 0;
	endfunction

	initial begin
		int target;
		int kind;
		int nd;
		logic [7:0] op;

		// Directed: styles, extremes, full colour code, out-of-range colour, third digit,
		// doubled lead, lone leads, bare comma and a lead cut off by end of text
		add_text("~b~u~iA");
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(CH_CTRL, 1'b0);
		add_text("12,05Z");
		add_text("~997~~");
		add_byte(CH_CTRL, 1'b0);
		add_text("q~q~C~c");
		add_byte(CH_CTRL, 1'b0);
		add_text("3,");
		add_byte(CH_TILDE, 1'b1);

		target = text_q.size() + RANDOM_BYTES;
		while (text_q.size() < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				add_byte(8'($urandom_range(0, 255)), rare_eot());
			end else if (kind < 70) begin
				add_byte(any_lead(), rare_eot());
				add_byte(any_digit(), rare_eot());
				if ($urandom_range(0, 1))
					add_byte(any_digit(), rare_eot());
				if ($urandom_range(0, 2) != 0) begin
					add_byte(CH_COMMA, rare_eot());
					nd = $urandom_range(0, 2);
					repeat (nd)
						add_byte(any_digit(), rare_eot());
				end
			end else if (kind < 85) begin
				case ($urandom_range(0, 6))
					0: op = CH_LC_C;
					1: op = CH_UC_C;
					2: op = CH_LC_B;
					3: op = CH_LC_U;
					4: op = CH_LC_I;
					5: op = CH_TILDE;
					default: op = CH_CTRL;
				endcase
				add_byte(any_lead(), rare_eot());
				add_byte(op, rare_eot());
			end else begin
				add_byte(any_lead(), rare_eot());
				add_byte(8'($urandom_range(0, 255)), rare_eot());
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: all bytes in, all results out, then let the pipeline settle
		while (text_q.size() != 0 || in_valid)
			@(negedge clk);
		while (glyph_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (glyph_q.size() != 0)
			n_bad += glyph_q.size();

		$display("Run covered %0d text bytes (%0d ending a string) and %0d checked results",
			n_in, n_eot, n_out);
		$display("Mismatches and stray results: %0d", n_bad);
		if (n_bad == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
